### src/obs_span_pkg.sv
package obs_span_pkg;

  localparam int unsigned MaxWidthDefault  = 1024;
  localparam int unsigned MaxHeightDefault = 1024;

  localparam int unsigned CfgDataW = 11;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned PixW     = 8;
  localparam int unsigned GrayW    = 8;

  // Register reset values
  localparam logic [10:0] FrameWidthRst    = 11'd640;
  localparam logic [10:0] FrameHeightRst   = 11'd480;
  localparam logic [7:0]  GrayThresholdRst = 8'd125;
  localparam logic [10:0] MaxSpanRst       = 11'd100;

  // BT.601 luma weights, Q14
  localparam logic [21:0] CoefBlue  = 22'd1868;
  localparam logic [21:0] CoefGreen = 22'd9617;
  localparam logic [21:0] CoefRed   = 22'd4899;
  localparam logic [21:0] GrayRound = 22'd8192;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_GRAY_THRESHOLD = 2'd2,
    REG_MAX_SPAN       = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_NONE = 2'd1,
    STATUS_WIDE = 2'd2
  } status_e;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [7:0]  gray_threshold;
    logic [10:0] max_span;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } beat_ctl_t;

  function automatic logic [GrayW-1:0] gray_of(input logic [PixW-1:0] b,
                                               input logic [PixW-1:0] g,
                                               input logic [PixW-1:0] r);
    logic [21:0] acc;
    acc = 22'(b) * CoefBlue + 22'(g) * CoefGreen + 22'(r) * CoefRed + GrayRound;
    return acc[21:14];
  endfunction

endpackage

### src/obs_pixel_if.sv
interface obs_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic       frame_end;

  modport source (output valid, blue, green, red, frame_end, input ready);
  modport sink   (input valid, blue, green, red, frame_end, output ready);
endinterface

### src/obs_result_if.sv
interface obs_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [9:0]  right_x;
  logic [10:0] left_x;
  logic [9:0]  span;

  modport source (output valid, status, right_x, left_x, span, input ready);
  modport sink   (input valid, status, right_x, left_x, span, output ready);
endinterface

### src/obstacle_span_from_pixels_unit.sv
// Channel   Dir  Payload                           Handshake
// pix_i     in   blue, green, red, frame_end       valid/ready, beat on both high
// res_o     out  status, right_x, left_x, span     valid/ready, beat on both high
// cfg       in   cfg_idx_i, cfg_wdata_i            cfg_we_i, no back-pressure
//
// Takes one pixel beat per clock with no bubbles between frames, unless a result waits.
// A frame's result follows its frame_end beat through the input register, the mark
// register and the result register, where it waits until the output is taken.
// Reset clears counters, extent flag, last x, all valid flags; registers return to defaults.
// A waiting result stalls only a following frame_end beat and beats behind it; earlier ones flow.
module obstacle_span_from_pixels_unit
  import obs_span_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = MaxHeightDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  obs_pixel_if.sink           pix_i,
  obs_result_if.source        res_o
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);

  cfg_t cfg_q, cfg_d;

  // Pixel register to mark register
  beat_ctl_t       pix_ctl;
  logic [PixW-1:0] pix_blue, pix_green, pix_red;
  logic [XW-1:0]   pix_x;
  logic [YW-1:0]   pix_y;
  logic            mark_ready;

  // Mark register to extent tracker
  beat_ctl_t     mark_ctl;
  logic          mark_hit;
  logic [XW-1:0] mark_x;
  logic          ext_ready;

  // Configuration write: decode index, keep the low bits each register needs
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_FRAME_WIDTH:    cfg_d.frame_width    = cfg_wdata_i;
        REG_FRAME_HEIGHT:   cfg_d.frame_height   = cfg_wdata_i;
        REG_GRAY_THRESHOLD: cfg_d.gray_threshold = cfg_wdata_i[7:0];
        REG_MAX_SPAN:       cfg_d.max_span       = cfg_wdata_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= FrameWidthRst;
      cfg_q.frame_height   <= FrameHeightRst;
      cfg_q.gray_threshold <= GrayThresholdRst;
      cfg_q.max_span       <= MaxSpanRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Capture pixel and its raster position
  obs_span_pixel_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pixel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .pix_i   (pix_i),
    .ctl_o   (pix_ctl),
    .blue_o  (pix_blue),
    .green_o (pix_green),
    .red_o   (pix_red),
    .x_o     (pix_x),
    .y_o     (pix_y),
    .ready_i (mark_ready)
  );

  // Gray conversion, threshold and region test
  obs_span_mark_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_mark (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .ctl_i    (pix_ctl),
    .blue_i   (pix_blue),
    .green_i  (pix_green),
    .red_i    (pix_red),
    .x_i      (pix_x),
    .y_i      (pix_y),
    .ready_o  (mark_ready),
    .ctl_o    (mark_ctl),
    .marked_o (mark_hit),
    .x_o      (mark_x),
    .ready_i  (ext_ready)
  );

  // Track leftmost and last marked x, emit the frame result
  obs_span_extent_stage #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_extent (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .ctl_i    (mark_ctl),
    .marked_i (mark_hit),
    .x_i      (mark_x),
    .ready_o  (ext_ready),
    .res_o    (res_o)
  );

endmodule

### src/obs_span_pixel_stage.sv
module obs_span_pixel_stage
  import obs_span_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = MaxHeightDefault,
  localparam int unsigned XW = $clog2(MAX_WIDTH),
  localparam int unsigned YW = $clog2(MAX_HEIGHT)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  obs_pixel_if.sink       pix_i,
  output beat_ctl_t       ctl_o,
  output logic [PixW-1:0] blue_o,
  output logic [PixW-1:0] green_o,
  output logic [PixW-1:0] red_o,
  output logic [XW-1:0]   x_o,
  output logic [YW-1:0]   y_o,
  input  logic            ready_i
);

  localparam int unsigned XCW = (XW + 1 > 11) ? XW + 1 : 11;

  logic [XW-1:0]   col_q, col_d;
  logic [YW-1:0]   row_q, row_d;
  logic            pv_q, pv_d;
  logic            plast_q;
  logic [PixW-1:0] pb_q, pg_q, pr_q;
  logic [XW-1:0]   px_q;
  logic [YW-1:0]   py_q;
  logic [XW:0]     col_inc;
  logic            wrap;
  logic            accept;

  assign pix_i.ready = !pv_q || ready_i;
  assign accept      = pix_i.valid && pix_i.ready;

  assign col_inc = {1'b0, col_q} + {{XW{1'b0}}, 1'b1};
  assign wrap    = (XCW'(col_inc) >= XCW'(cfg_i.frame_width))
                || (col_inc >= (XW+1)'(MAX_WIDTH));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (pix_i.frame_end) begin
        col_d = '0;
        row_d = '0;
      end else if (wrap) begin
        col_d = '0;
        if (row_q != YW'(MAX_HEIGHT - 1)) begin
          row_d = row_q + YW'(1);
        end
      end else begin
        col_d = col_inc[XW-1:0];
      end
    end
  end

  assign pv_d = accept ? 1'b1 : (ready_i ? 1'b0 : pv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      pv_q  <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      pv_q  <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pb_q    <= pix_i.blue;
      pg_q    <= pix_i.green;
      pr_q    <= pix_i.red;
      plast_q <= pix_i.frame_end;
      px_q    <= col_q;
      py_q    <= row_q;
    end
  end

  assign ctl_o.valid = pv_q;
  assign ctl_o.last  = plast_q;
  assign blue_o      = pb_q;
  assign green_o     = pg_q;
  assign red_o       = pr_q;
  assign x_o         = px_q;
  assign y_o         = py_q;

  a_frame_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && pix_i.frame_end |=> (col_q == '0) && (row_q == '0))
    else $error("position counters not cleared after frame end");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !pix_i.frame_end && !wrap |=> col_q == $past(col_q) + XW'(1))
    else $error("column did not advance by one");

  a_row_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !pix_i.frame_end && (row_q == YW'(MAX_HEIGHT - 1)) |=>
    row_q == YW'(MAX_HEIGHT - 1))
    else $error("row counter ran past its last row");

endmodule

### src/obs_span_mark_stage.sv
module obs_span_mark_stage
  import obs_span_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = MaxHeightDefault,
  localparam int unsigned XW = $clog2(MAX_WIDTH),
  localparam int unsigned YW = $clog2(MAX_HEIGHT)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  beat_ctl_t       ctl_i,
  input  logic [PixW-1:0] blue_i,
  input  logic [PixW-1:0] green_i,
  input  logic [PixW-1:0] red_i,
  input  logic [XW-1:0]   x_i,
  input  logic [YW-1:0]   y_i,
  output logic            ready_o,
  output beat_ctl_t       ctl_o,
  output logic            marked_o,
  output logic [XW-1:0]   x_o,
  input  logic            ready_i
);

  localparam int unsigned XCW = (XW > 13) ? XW : 13;
  localparam int unsigned YCW = (YW > 11) ? YW : 11;

  logic [GrayW-1:0] gray;
  logic [12:0]      fw3;
  logic             in_roi;
  logic             take;
  logic             mv_q, mv_d;
  logic             mlast_q, marked_q;
  logic [XW-1:0]    mx_q;

  assign gray = gray_of(blue_i, green_i, red_i);
  assign fw3  = {2'b00, cfg_i.frame_width} + {1'b0, cfg_i.frame_width, 1'b0};

  // Region of interest: middle half of the columns, lower three quarters of rows
  assign in_roi = (XCW'(x_i) >= XCW'(cfg_i.frame_width >> 2))
               && (XCW'(x_i) <= XCW'(fw3 >> 2))
               && (YCW'(y_i) >= YCW'(cfg_i.frame_height >> 2));

  assign ready_o = !mv_q || ready_i;
  assign take    = ctl_i.valid && ready_o;
  assign mv_d    = take ? 1'b1 : (ready_i ? 1'b0 : mv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else begin
      mv_q <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      marked_q <= in_roi && (gray >= cfg_i.gray_threshold);
      mlast_q  <= ctl_i.last;
      mx_q     <= x_i;
    end
  end

  assign ctl_o.valid = mv_q;
  assign ctl_o.last  = mlast_q;
  assign marked_o    = marked_q;
  assign x_o         = mx_q;

endmodule

### src/obs_span_extent_stage.sv
module obs_span_extent_stage
  import obs_span_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MaxWidthDefault,
  localparam int unsigned XW = $clog2(MAX_WIDTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  beat_ctl_t     ctl_i,
  input  logic          marked_i,
  input  logic [XW-1:0] x_i,
  output logic          ready_o,
  obs_result_if.source  res_o
);

  localparam int unsigned SCW = (XW > 11) ? XW : 11;

  logic          any_q, any_d, any_n;
  logic [XW-1:0] min_q, min_d, min_n;
  logic [XW-1:0] last_q, last_d, last_n;
  logic [XW-1:0] span_full;
  logic          out_free, adv, load;
  logic          ov_q, ov_d;
  status_e       status_q, status_d;
  logic [9:0]    right_q, right_d;
  logic [10:0]   left_q, left_d;
  logic [9:0]    span_q, span_d;

  assign out_free = !ov_q || res_o.ready;
  assign ready_o  = !ctl_i.last || out_free;
  assign adv      = ctl_i.valid && ready_o;
  assign load     = adv && ctl_i.last;

  // Fold the current beat into the running extent
  assign any_n  = any_q || marked_i;
  assign min_n  = (marked_i && (!any_q || (x_i < min_q))) ? x_i : min_q;
  assign last_n = marked_i ? x_i : last_q;
  assign span_full = last_n - min_n;

  always_comb begin
    any_d  = any_q;
    min_d  = min_q;
    last_d = last_q;
    if (adv) begin
      if (ctl_i.last) begin
        any_d  = 1'b0;
        last_d = '0;
      end else begin
        any_d  = any_n;
        min_d  = min_n;
        last_d = last_n;
      end
    end
  end

  always_comb begin
    if (!any_n) begin
      status_d = STATUS_NONE;
      right_d  = '0;
      left_d   = cfg_i.frame_width;
      span_d   = '0;
    end else begin
      right_d = 10'(last_n);
      left_d  = 11'(min_n);
      if (SCW'(span_full) < SCW'(cfg_i.max_span)) begin
        status_d = STATUS_OK;
        span_d   = 10'(span_full);
      end else begin
        status_d = STATUS_WIDE;
        span_d   = '0;
      end
    end
  end

  assign ov_d = load ? 1'b1 : (res_o.ready ? 1'b0 : ov_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q  <= 1'b0;
      last_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      any_q  <= any_d;
      last_q <= last_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    if (load) begin
      status_q <= status_d;
      right_q  <= right_d;
      left_q   <= left_d;
      span_q   <= span_d;
    end
  end

  assign res_o.valid   = ov_q;
  assign res_o.status  = status_q;
  assign res_o.right_x = right_q;
  assign res_o.left_x  = left_q;
  assign res_o.span    = span_q;

  a_extent_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q |-> last_q >= min_q)
    else $error("last marked x fell left of the leftmost marked x");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && (status_q == STATUS_NONE) |-> (right_q == '0) && (span_q == '0))
    else $error("empty frame reported a position");

  a_wide_no_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && (status_q == STATUS_WIDE) |-> span_q == '0)
    else $error("rejected span not zeroed");

  a_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> !any_q && ov_q)
    else $error("frame end did not clear extent or raise result");

endmodule
